@@ design/pqmt_pkg.sv @@
package pqmt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    // Child indexes run up to 2*CAPACITY, which needs two bits above a slot address.
    localparam int CHILD_W  = ADDR_W + 2;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 16;
    localparam int SCORE_W  = 10;
    localparam int TAG_W    = 16;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT        = 2'd0,
        CMD_INSERT_REPORT = 2'd1,
        CMD_PEEK          = 2'd2,
        CMD_POP           = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_TOP   = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_CAP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CHOOSE,
        S_DN_TEST,
        S_TOP_RD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        entry_t  entry;
    } result_t;

endpackage

@@ design/pqmt_in_if.sv @@
interface pqmt_in_if;
    logic                       valid;
    logic                       ready;
    logic [pqmt_pkg::CMD_W-1:0]   command;
    logic [pqmt_pkg::ID_W-1:0]    entry_id;
    logic [pqmt_pkg::SCORE_W-1:0] score;
    logic [pqmt_pkg::TAG_W-1:0]   tag;

    modport source (output valid, command, entry_id, score, tag, input ready);
    modport sink (input valid, command, entry_id, score, tag, output ready);
endinterface

@@ design/pqmt_out_if.sv @@
interface pqmt_out_if;
    logic                          valid;
    logic                          ready;
    logic [pqmt_pkg::STATUS_W-1:0] status;
    logic [pqmt_pkg::ID_W-1:0]     top_id;
    logic [pqmt_pkg::SCORE_W-1:0]  top_score;
    logic [pqmt_pkg::TAG_W-1:0]    top_tag;

    modport source (output valid, status, top_id, top_score, top_tag, input ready);
    modport sink (input valid, status, top_id, top_score, top_tag, output ready);
endinterface

@@ design/pqmt_ram.sv @@
module pqmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/pqmt_rank.sv @@
module pqmt_rank (
    input  pqmt_pkg::entry_t a,
    input  pqmt_pkg::entry_t b,
    output logic             below
);

    // Higher score ranks higher; on equal scores the lower id ranks higher.
    always_comb
    begin
        if (a.score != b.score)
        begin
            below = (a.score < b.score);
        end
        else
        begin
            below = (a.id > b.id);
        end
    end

endmodule

@@ design/pqmt_seq.sv @@
module pqmt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pqmt_pkg::cmd_t      in_cmd,
    input  pqmt_pkg::entry_t    in_entry,
    output pqmt_pkg::mem_req_t  mem_req,
    input  pqmt_pkg::entry_t    mem_rdata,
    output pqmt_pkg::result_t   res,
    input  logic                res_ready
);

    pqmt_pkg::state_t                  state_reg, state_next;
    logic [pqmt_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [pqmt_pkg::ADDR_W-1:0]       idx_reg, idx_next;
    logic [pqmt_pkg::ADDR_W-1:0]       cidx_reg, cidx_next;
    pqmt_pkg::entry_t                  cur_reg, cur_next;
    pqmt_pkg::entry_t                  lft_reg, lft_next;
    pqmt_pkg::entry_t                  child_reg, child_next;
    pqmt_pkg::status_t                 status_reg, status_next;
    logic                              report_reg, report_next;

    pqmt_pkg::entry_t                  cmp_a, cmp_b;
    logic                              below;
    logic                              accept;
    logic                              full;
    logic                              empty;
    logic [pqmt_pkg::CHILD_W-1:0]      l_idx, r_idx, n_ext;
    logic                              l_ge_n, r_lt_n;
    logic [pqmt_pkg::ADDR_W-1:0]       parent_idx;
    pqmt_pkg::state_t                  finish_state;

    pqmt_rank u_rank (
        .a     (cmp_a),
        .b     (cmp_b),
        .below (below)
    );

    assign in_ready     = (state_reg == pqmt_pkg::S_IDLE);
    assign accept       = in_valid && in_ready;
    assign full         = (count_reg == pqmt_pkg::COUNT_W'(pqmt_pkg::CAPACITY));
    assign empty        = (count_reg == '0);
    assign l_idx        = pqmt_pkg::CHILD_W'({idx_reg, 1'b1});
    assign r_idx        = l_idx + pqmt_pkg::CHILD_W'(1);
    assign n_ext        = pqmt_pkg::CHILD_W'(count_reg);
    assign l_ge_n       = (l_idx >= n_ext);
    assign r_lt_n       = (r_idx < n_ext);
    assign parent_idx   = (idx_reg - pqmt_pkg::ADDR_W'(1)) >> 1;
    assign finish_state = report_reg ? pqmt_pkg::S_TOP_RD : pqmt_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pqmt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        pqmt_pkg::CMD_INSERT, pqmt_pkg::CMD_INSERT_REPORT:
                            state_next = full ? pqmt_pkg::S_RESULT : pqmt_pkg::S_UP_RD;
                        pqmt_pkg::CMD_PEEK:
                            state_next = empty ? pqmt_pkg::S_RESULT : pqmt_pkg::S_TOP_RD;
                        default:
                            state_next = (count_reg <= pqmt_pkg::COUNT_W'(1)) ?
                                         pqmt_pkg::S_RESULT : pqmt_pkg::S_POP_CAP;
                    endcase
                end
            end
            pqmt_pkg::S_UP_RD:
                state_next = (idx_reg == '0) ? finish_state : pqmt_pkg::S_UP_CMP;
            pqmt_pkg::S_UP_CMP:
                state_next = below ? pqmt_pkg::S_UP_RD : finish_state;
            pqmt_pkg::S_POP_CAP:
                state_next = pqmt_pkg::S_DN_RDL;
            pqmt_pkg::S_DN_RDL:
                state_next = l_ge_n ? finish_state : pqmt_pkg::S_DN_RDR;
            pqmt_pkg::S_DN_RDR:
                state_next = r_lt_n ? pqmt_pkg::S_DN_CHOOSE : pqmt_pkg::S_DN_TEST;
            pqmt_pkg::S_DN_CHOOSE:
                state_next = pqmt_pkg::S_DN_TEST;
            pqmt_pkg::S_DN_TEST:
                state_next = below ? pqmt_pkg::S_DN_RDL : finish_state;
            pqmt_pkg::S_TOP_RD:
                state_next = pqmt_pkg::S_RESULT;
            pqmt_pkg::S_RESULT:
                state_next = res_ready ? pqmt_pkg::S_IDLE : pqmt_pkg::S_RESULT;
            default:
                state_next = pqmt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        cidx_next   = cidx_reg;
        cur_next    = cur_reg;
        lft_next    = lft_reg;
        child_next  = child_reg;
        status_next = status_reg;
        report_next = report_reg;
        mem_req     = '0;
        res         = '0;
        cmp_a       = cur_reg;
        cmp_b       = child_reg;

        case (state_reg)
            pqmt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    report_next = (in_cmd != pqmt_pkg::CMD_INSERT);
                    cur_next    = in_entry;
                    case (in_cmd)
                        pqmt_pkg::CMD_INSERT, pqmt_pkg::CMD_INSERT_REPORT:
                        begin
                            if (full)
                            begin
                                status_next = pqmt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                idx_next   = pqmt_pkg::ADDR_W'(count_reg);
                                count_next = count_reg + pqmt_pkg::COUNT_W'(1);
                            end
                        end
                        pqmt_pkg::CMD_PEEK:
                        begin
                            status_next = empty ? pqmt_pkg::STATUS_EMPTY : pqmt_pkg::STATUS_TOP;
                        end
                        default:
                        begin
                            status_next = pqmt_pkg::STATUS_EMPTY;
                            if (!empty)
                            begin
                                count_next = count_reg - pqmt_pkg::COUNT_W'(1);
                            end
                            // The last entry becomes the new root and sifts down from there.
                            if (count_reg > pqmt_pkg::COUNT_W'(1))
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pqmt_pkg::ADDR_W'(count_reg -
                                                  pqmt_pkg::COUNT_W'(1));
                                idx_next        = '0;
                            end
                        end
                    endcase
                end
            end
            pqmt_pkg::S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg;
                    mem_req.wr_data = cur_reg;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = parent_idx;
                end
            end
            pqmt_pkg::S_UP_CMP:
            begin
                // The hole moves up: the parent drops into it while the new entry outranks it.
                cmp_a           = mem_rdata;
                cmp_b           = cur_reg;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                if (below)
                begin
                    mem_req.wr_data = mem_rdata;
                    idx_next        = parent_idx;
                end
                else
                begin
                    mem_req.wr_data = cur_reg;
                end
            end
            pqmt_pkg::S_POP_CAP:
            begin
                cur_next = mem_rdata;
            end
            pqmt_pkg::S_DN_RDL:
            begin
                if (l_ge_n)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg;
                    mem_req.wr_data = cur_reg;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = l_idx[pqmt_pkg::ADDR_W-1:0];
                end
            end
            pqmt_pkg::S_DN_RDR:
            begin
                lft_next   = mem_rdata;
                child_next = mem_rdata;
                cidx_next  = l_idx[pqmt_pkg::ADDR_W-1:0];
                if (r_lt_n)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx[pqmt_pkg::ADDR_W-1:0];
                end
            end
            pqmt_pkg::S_DN_CHOOSE:
            begin
                // The right child wins only when the left one ranks below it.
                cmp_a = lft_reg;
                cmp_b = mem_rdata;
                if (below)
                begin
                    child_next = mem_rdata;
                    cidx_next  = r_idx[pqmt_pkg::ADDR_W-1:0];
                end
            end
            pqmt_pkg::S_DN_TEST:
            begin
                cmp_a           = cur_reg;
                cmp_b           = child_reg;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                if (below)
                begin
                    mem_req.wr_data = child_reg;
                    idx_next        = cidx_reg;
                end
                else
                begin
                    mem_req.wr_data = cur_reg;
                end
            end
            pqmt_pkg::S_TOP_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                status_next     = pqmt_pkg::STATUS_TOP;
            end
            pqmt_pkg::S_RESULT:
            begin
                // The memory holds its read data while no read is issued.
                res.valid  = 1'b1;
                res.status = status_reg;
                res.entry  = (status_reg == pqmt_pkg::STATUS_TOP) ? mem_rdata : '0;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pqmt_pkg::S_IDLE;
            count_reg  <= '0;
            report_reg <= 1'b0;
            status_reg <= pqmt_pkg::STATUS_TOP;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            report_reg <= report_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        cidx_reg  <= cidx_next;
        cur_reg   <= cur_next;
        lft_reg   <= lft_next;
        child_reg <= child_next;
    end

endmodule

@@ design/priority_queue_max_with_tiebreak.sv @@
// Bounded max priority queue kept as a binary heap in a single memory with one read
// and one write port, walked by a small sequencer around one shared rank comparator.
// The highest score comes first and equal scores go to the lower id. A request is
// taken only while the sequencer is idle. An insert climbs up to log2(CAPACITY) heap
// levels, reading each parent and comparing it with the new entry, then reads the top
// if it reports; an insert into a full queue goes straight to its result. A pop moves
// the last entry to the root and sinks it, reading the left and any right child, choosing
// between them and testing; a peek reads the top. Popping at most one entry or peeking
// an empty queue goes straight to the result. The memory's single registered read port
// feeding the shared comparator sets this walk. Results leave through an output
// register, so the next request can be taken while a result still waits downstream; a
// further result waits in the sequencer until that register frees up. The heap memory
// needs no clearing after reset; only the entry count and the control state are reset.
module priority_queue_max_with_tiebreak (
    input logic        clk,
    input logic        rst_n,
    pqmt_in_if.sink    request,
    pqmt_out_if.source result
);

    pqmt_pkg::mem_req_t mem_req;
    pqmt_pkg::entry_t   mem_rdata;
    pqmt_pkg::entry_t   in_entry;
    pqmt_pkg::result_t  res;
    logic               res_ready;

    logic                      out_valid_reg, out_valid_next;
    pqmt_pkg::status_t         out_status_reg, out_status_next;
    pqmt_pkg::entry_t          out_entry_reg, out_entry_next;

    assign in_entry.score = request.score;
    assign in_entry.id    = request.entry_id;
    assign in_entry.tag   = request.tag;

    pqmt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_cmd    (pqmt_pkg::cmd_t'(request.command)),
        .in_entry  (in_entry),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_ready (res_ready)
    );

    pqmt_ram #(
        .WIDTH (pqmt_pkg::ENTRY_W),
        .DEPTH (pqmt_pkg::CAPACITY)
    ) u_heap (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rdata)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res.status;
            out_entry_next  = res.entry;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.status    = out_status_reg;
    assign result.top_id    = out_entry_reg.id;
    assign result.top_score = out_entry_reg.score;
    assign result.top_tag   = out_entry_reg.tag;

endmodule

@@ dv/pqmt_order_check.sv @@
`timescale 1ns / 1ps
module pqmt_order_check (
    input  logic clk,
    input  logic rst_n,
    pqmt_in_if   req_bus,
    pqmt_out_if  res_bus,
    output int   mismatch_count,
    output int   pending_count
);

    typedef struct packed {
        pqmt_pkg::status_t status;
        pqmt_pkg::entry_t  top;
    } report_t;

    pqmt_pkg::entry_t heap_slots [pqmt_pkg::CAPACITY];
    int unsigned      held;
    report_t          expected_reports [$];
    int               errors;

    // True when a must be served after b.
    function automatic bit ranks_lower(input pqmt_pkg::entry_t a, input pqmt_pkg::entry_t b);
        if (a.score != b.score)
            return a.score < b.score;
        return a.id > b.id;
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        pqmt_pkg::entry_t t;
        t = heap_slots[a];
        heap_slots[a] = heap_slots[b];
        heap_slots[b] = t;
    endfunction

    function automatic bit heap_push(input pqmt_pkg::entry_t e);
        int unsigned i;
        int unsigned up;
        bit settled;
        if (held >= pqmt_pkg::CAPACITY)
            return 1'b0;
        i = held;
        heap_slots[i] = e;
        held++;
        settled = 1'b0;
        while (!settled && i > 0)
        begin
            up = (i - 1) / 2;
            if (ranks_lower(heap_slots[up], heap_slots[i]))
            begin
                swap_slots(up, i);
                i = up;
            end
            else
                settled = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void heap_pop();
        int unsigned i;
        int unsigned l;
        int unsigned r;
        int unsigned c;
        bit settled;
        if (held == 0)
            return;
        held--;
        if (held == 0)
            return;
        heap_slots[0] = heap_slots[held];
        i = 0;
        settled = 1'b0;
        while (!settled)
        begin
            l = 2 * i + 1;
            r = l + 1;
            if (l >= held)
                settled = 1'b1;
            else
            begin
                // The right child wins only when the left one ranks strictly lower.
                c = l;
                if (r < held && ranks_lower(heap_slots[l], heap_slots[r]))
                    c = r;
                if (ranks_lower(heap_slots[i], heap_slots[c]))
                begin
                    swap_slots(i, c);
                    i = c;
                end
                else
                    settled = 1'b1;
            end
        end
    endfunction

    function automatic report_t top_report();
        report_t rep;
        rep = '0;
        if (held == 0)
            rep.status = pqmt_pkg::STATUS_EMPTY;
        else
        begin
            rep.status = pqmt_pkg::STATUS_TOP;
            rep.top = heap_slots[0];
        end
        return rep;
    endfunction

    function automatic bit predict_report(input pqmt_pkg::cmd_t cmd,
                                          input pqmt_pkg::entry_t e,
                                          output report_t rep);
        rep = '0;
        case (cmd)
            pqmt_pkg::CMD_INSERT:
            begin
                if (heap_push(e))
                    return 1'b0;
                rep.status = pqmt_pkg::STATUS_FULL;
            end
            pqmt_pkg::CMD_INSERT_REPORT:
            begin
                if (heap_push(e))
                    rep = top_report();
                else
                    rep.status = pqmt_pkg::STATUS_FULL;
            end
            pqmt_pkg::CMD_PEEK:
                rep = top_report();
            default:
            begin
                heap_pop();
                rep = top_report();
            end
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t          want;
        pqmt_pkg::entry_t e;
        if (!rst_n)
        begin
            held = 0;
            expected_reports.delete();
            errors = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            // The result side goes first: a request taken at this edge cannot
            // have produced the result taken at the same edge.
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result status %0d id %0d score %0d tag %0d",
                                 $realtime, res_bus.status, res_bus.top_id,
                                 res_bus.top_score, res_bus.top_tag);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (res_bus.status !== want.status || res_bus.top_id !== want.top.id
                        || res_bus.top_score !== want.top.score
                        || res_bus.top_tag !== want.top.tag)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: result mismatch: expected status %0d id %0d ",
                                      "score %0d tag %0d, got status %0d id %0d ",
                                      "score %0d tag %0d"},
                                     $realtime, want.status, want.top.id, want.top.score,
                                     want.top.tag, res_bus.status, res_bus.top_id,
                                     res_bus.top_score, res_bus.top_tag);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                e.score = req_bus.score;
                e.id = req_bus.entry_id;
                e.tag = req_bus.tag;
                if (predict_report(pqmt_pkg::cmd_t'(req_bus.command), e, want))
                    expected_reports.push_back(want);
            end
            mismatch_count <= errors;
            pending_count <= expected_reports.size();
        end
    end

endmodule

@@ dv/tb_priority_queue_max_with_tiebreak.sv @@
`timescale 1ns / 1ps
module tb_priority_queue_max_with_tiebreak;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_CYCLES     = 500;
    localparam int HOLD_AT         = 350;
    localparam int SETTLE_CYCLES   = 100;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mode_t;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_count;
    int   pending_count;
    int   cycle_count = 0;
    int   sent_count = 0;
    bit   hold_results = 1'b0;

    pqmt_in_if  request_bus ();
    pqmt_out_if result_bus ();

    priority_queue_max_with_tiebreak DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .result  (result_bus)
    );

    pqmt_order_check u_order_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_bus        (request_bus),
        .res_bus        (result_bus),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("priority_queue_max_with_tiebreak test failed");
            $finish;
        end
    end

    // Mostly no idle, a few short gaps, and now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic offer_request(input pqmt_pkg::cmd_t cmd,
                                 input logic [pqmt_pkg::ID_W-1:0] id,
                                 input logic [pqmt_pkg::SCORE_W-1:0] sc,
                                 input logic [pqmt_pkg::TAG_W-1:0] tg);
        request_bus.valid <= 1'b1;
        request_bus.command <= cmd;
        request_bus.entry_id <= id;
        request_bus.score <= sc;
        request_bus.tag <= tg;
        @(posedge clk);
        while (!request_bus.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic sender_gap(input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_random(input mode_t mode);
        pqmt_pkg::cmd_t               cmd;
        int                           r;
        logic [pqmt_pkg::ID_W-1:0]    id;
        logic [pqmt_pkg::SCORE_W-1:0] sc;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                cmd = r < 45 ? pqmt_pkg::CMD_INSERT : r < 85 ? pqmt_pkg::CMD_INSERT_REPORT :
                      r < 95 ? pqmt_pkg::CMD_PEEK : pqmt_pkg::CMD_POP;
            MODE_DRAIN:
                cmd = r < 10 ? pqmt_pkg::CMD_INSERT : r < 20 ? pqmt_pkg::CMD_INSERT_REPORT :
                      r < 30 ? pqmt_pkg::CMD_PEEK : pqmt_pkg::CMD_POP;
            default:
                cmd = r < 25 ? pqmt_pkg::CMD_INSERT : r < 50 ? pqmt_pkg::CMD_INSERT_REPORT :
                      r < 75 ? pqmt_pkg::CMD_PEEK : pqmt_pkg::CMD_POP;
        endcase
        // Narrow ranges make score ties and exact duplicates common.
        r = $urandom_range(0, 99);
        sc = pqmt_pkg::SCORE_W'(r < 30 ? $urandom_range(0, 3) : r < 35 ? 0 :
                                r < 40 ? 1023 : $urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        id = pqmt_pkg::ID_W'(r < 30 ? $urandom_range(0, 3) : $urandom_range(0, 65535));
        offer_request(cmd, id, sc, pqmt_pkg::TAG_W'($urandom_range(0, 65535)));
    endtask

    // Result side: random ready pattern, plus one long hold-off on request.
    initial
    begin
        int run;
        int gap;
        int held_cycles;
        bit hold_taken;
        hold_taken = 1'b0;
        result_bus.ready <= 1'b0;
        forever
        begin
            if (hold_results && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_bus.ready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
                    @(posedge clk);
            end
            run = $urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20);
            result_bus.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        mode_t mode;
        int    phase_len;
        int    n;
        bit    burst;
        rst_n <= 1'b0;
        request_bus.valid <= 1'b0;
        request_bus.command <= pqmt_pkg::CMD_PEEK;
        request_bus.entry_id <= '0;
        request_bus.score <= '0;
        request_bus.tag <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, a pop that empties it, extremes and exact ties.
        offer_request(pqmt_pkg::CMD_PEEK, 16'd0, 10'd0, 16'd0);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_POP, 16'hFFFF, 10'h3FF, 16'hFFFF);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT_REPORT, 16'd0, 10'd0, 16'd0);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_POP, 16'd0, 10'd0, 16'd0);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT, 16'hFFFF, 10'h3FF, 16'hFFFF);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT_REPORT, 16'd0, 10'h3FF, 16'h5555);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT_REPORT, 16'd0, 10'h3FF, 16'hAAAA);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT_REPORT, 16'd1, 10'd0, 16'h0001);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT, 16'd7, 10'd512, 16'h1234);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_INSERT_REPORT, 16'd8, 10'd512, 16'h8000);
        sender_gap(1'b0);
        offer_request(pqmt_pkg::CMD_PEEK, 16'hFFFF, 10'h3FF, 16'hFFFF);
        for (n = 0; n < 8; n++)
        begin
            sender_gap(1'b0);
            offer_request(pqmt_pkg::CMD_POP, 16'd0, 10'd0, 16'd0);
        end

        // The first phase fills the queue past capacity; later phases are random.
        mode = MODE_FILL;
        phase_len = 90;
        while (sent_count < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(0, 4) == 0;
            for (n = 0; n < phase_len && sent_count < RANDOM_REQUESTS; n++)
            begin
                if (sent_count >= HOLD_AT)
                    hold_results = 1'b1;
                offer_random(mode);
                sender_gap(burst);
            end
            case ($urandom_range(0, 2))
                0: mode = MODE_FILL;
                1: mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            phase_len = $urandom_range(20, 120);
        end
        request_bus.valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("priority_queue_max_with_tiebreak test passed");
        else
            $display("priority_queue_max_with_tiebreak test failed");
        $finish;
    end

endmodule
